// ===== sv/tdvtu_pkg.sv =====
`default_nettype none
package tdvtu_pkg;

    localparam int SLOTS       = 16;
    localparam int GENE_BITS   = 8;
    localparam int ROW_LEN     = 1 << GENE_BITS;
    localparam int TABLE_DEPTH = SLOTS * ROW_LEN;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LEARN_RATE = 2'd0;
    localparam t_cfg_idx CFG_DISCOUNT   = 2'd1;

    localparam logic [15:0] LEARN_RATE_RST = 16'd3277;
    localparam logic [15:0] DISCOUNT_RST   = 16'd29491;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic              opcode;
        logic [3:0]        slot;
        logic [7:0]        new_chromosome;
        logic [7:0]        old_chromosome;
        logic signed [31:0] reward;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic              saturated;
    } t_out_item;

    typedef struct packed {
        logic [15:0] learn_rate;
        logic [15:0] discount;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic              is_update;
        logic              in_range;
        t_addr             addr_new;
        t_addr             addr_old;
        logic signed [31:0] reward;
    } t_job;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_DIFF,
        B_STEP,
        B_WB
    } t_bstate;

endpackage
`default_nettype wire

// ===== sv/td_value_table_update.sv =====
// flow: the back-end sequencer finishes one request before it takes the next; a query ends
//   after the table read, an update goes on through discount multiply, difference, rate
//   multiply and write-back
// reset: synchronous active low; clears queues, loads default rates, then sweeps the table
//   to zero one entry a cycle (all 4096 entries) with full held high
`default_nettype none
module td_value_table_update
    import tdvtu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    input  t_in_item  i_in,
    output logic      full,
    output logic      empty,
    input  wire logic pop,
    output t_out_item o_res,
    input  wire logic i_cfg_we,
    input  t_cfg_idx  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      w_job_valid;
    t_job      w_job;
    logic      w_job_pop;
    logic      w_clearing;
    logic      w_res_room;
    logic      w_res_push;
    t_out_item w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learn_rate <= LEARN_RATE_RST;
            r_cfg.discount   <= DISCOUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEARN_RATE: r_cfg.learn_rate <= i_cfg_data;
                CFG_DISCOUNT:   r_cfg.discount   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tdvtu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in        (i_in),
        .o_full      (full),
        .i_clearing  (w_clearing),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    tdvtu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_clearing  (w_clearing),
        .i_res_room  (w_res_room),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    tdvtu_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_item  (w_res),
        .o_room  (w_res_room),
        .o_empty (empty),
        .i_pop   (pop),
        .o_item  (o_res)
    );

endmodule
`default_nettype wire

// ===== sv/tdvtu_front.sv =====
`default_nettype none
module tdvtu_front
    import tdvtu_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  t_in_item      i_in,
    output logic          o_full,
    input  wire logic     i_clearing,
    output logic          o_job_valid,
    output t_job          o_job,
    input  wire logic     i_job_pop
);

    function automatic t_addr table_addr(logic [3:0] slot, logic [7:0] chrom);
        logic [GENE_BITS-1:0] col;
        logic [3+GENE_BITS:0] idx;
        col = GENE_BITS'(chrom);
        idx = {slot, col};
        return ADDR_W'(idx);
    endfunction

    t_job       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_job       w_job;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_job.is_update = i_in.opcode;
        w_job.in_range  = 32'(i_in.slot) < SLOTS;
        w_job.addr_new  = table_addr(i_in.slot, i_in.new_chromosome);
        w_job.addr_old  = table_addr(i_in.slot, i_in.old_chromosome);
        w_job.reward    = i_in.reward;
    end

    assign o_full      = i_clearing || (r_count == 2'd2);
    assign w_push      = i_push && !o_full;
    assign o_job_valid = (r_count != 2'd0);
    assign w_pop       = i_job_pop && o_job_valid;
    assign o_job       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ w_pop;
        n_count  = r_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

endmodule
`default_nettype wire

// ===== sv/tdvtu_res_q.sv =====
`default_nettype none
module tdvtu_res_q
    import tdvtu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_out_item i_item,
    output logic      o_room,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_out_item o_item
);

    t_out_item  r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_pop;

    assign o_room  = (r_count != 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr ^ i_push;
            r_rd_ptr <= r_rd_ptr ^ w_pop;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== sv/tdvtu_back.sv =====
`default_nettype none
module tdvtu_back
    import tdvtu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    output logic      o_clearing,
    input  wire logic i_res_room,
    output logic      o_res_push,
    output t_out_item o_res
);

    localparam logic signed [38:0] SUM_MAX = 39'sd2147483647;
    localparam logic signed [38:0] SUM_MIN = -39'sd2147483648;

    t_bstate r_state, n_state;
    t_addr   r_clr_addr, n_clr_addr;
    t_job    r_job;

    logic signed [31:0] r_mem [TABLE_DEPTH];
    logic signed [31:0] r_vnew;
    logic signed [31:0] r_vold;
    logic signed [48:0] r_disc_prod;
    logic signed [35:0] r_diff;
    logic signed [52:0] r_step_prod;

    logic               w_rd_en;
    logic               w_we;
    t_addr              w_waddr;
    logic signed [31:0] w_wdata;
    logic signed [35:0] w_diff;
    logic signed [38:0] w_sum;
    logic signed [31:0] w_sum_clamped;
    logic               w_sat;
    logic               w_clr_done;

    assign w_clr_done = (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1));

    // floor shift by 15 is the arithmetic part-select of the exact product
    assign w_diff = 36'(r_job.reward) + 36'($signed(r_disc_prod[48:15])) - 36'(r_vold);
    assign w_sum  = 39'(r_vold) + 39'($signed(r_step_prod[52:15]));

    always_comb begin
        w_sat         = 1'b0;
        w_sum_clamped = w_sum[31:0];
        if (w_sum > SUM_MAX) begin
            w_sat         = 1'b1;
            w_sum_clamped = 32'sh7fffffff;
        end else if (w_sum < SUM_MIN) begin
            w_sat         = 1'b1;
            w_sum_clamped = 32'sh80000000;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            B_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (w_clr_done) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_job_valid && i_res_room) begin
                    n_state = B_READ;
                end
            end
            B_READ: begin
                if (r_job.is_update && r_job.in_range) begin
                    n_state = B_DIFF;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_DIFF:  n_state = B_STEP;
            B_STEP:  n_state = B_WB;
            B_WB:    n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_clearing = 1'b0;
        o_job_pop  = 1'b0;
        w_rd_en    = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_job.addr_old;
        w_wdata    = w_sum_clamped;
        o_res_push = 1'b0;
        o_res      = '0;
        case (r_state)
            B_CLEAR: begin
                o_clearing = 1'b1;
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
            end
            B_IDLE: begin
                o_job_pop = i_job_valid && i_res_room;
                w_rd_en   = o_job_pop;
            end
            B_READ: begin
                // queries and out-of-range requests finish here
                if (!(r_job.is_update && r_job.in_range)) begin
                    o_res_push      = 1'b1;
                    o_res.value_out = (r_job.in_range && !r_job.is_update) ? r_vnew : '0;
                end
            end
            B_WB: begin
                w_we            = 1'b1;
                o_res_push      = 1'b1;
                o_res.value_out = w_sum_clamped;
                o_res.saturated = w_sat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_vnew <= r_mem[i_job.addr_new];
            r_vold <= r_mem[i_job.addr_old];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_READ) begin
            r_disc_prod <= $signed({1'b0, i_cfg.discount}) * r_vnew;
        end
        if (r_state == B_DIFF) begin
            r_diff <= w_diff;
        end
        if (r_state == B_STEP) begin
            r_step_prod <= $signed({1'b0, i_cfg.learn_rate}) * r_diff;
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
    import tdvtu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam t_cfg_idx CFG_SPARE_2 = 2'd2;
    localparam t_cfg_idx CFG_SPARE_3 = 2'd3;

    localparam logic [15:0] Q15_ONE = 16'd32768;
    localparam logic [15:0] Q15_MAX = 16'hFFFF;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      push;
    t_in_item  i_in;
    logic      full;
    logic      empty;
    logic      pop;
    t_out_item o_res;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    logic [15:0] i_cfg_data;

    // predictor copy of the table and rates
    logic signed [31:0] model_values [TABLE_DEPTH];
    logic [15:0]        rate_q15;
    logic [15:0]        discount_q15;

    t_out_item pending_results [$];

    bit tx_idle_on;
    bit rx_idle_on;
    int long_hold_cycles;

    int cycle_count;
    int requests_sent;
    int results_checked;
    int saturations_seen;
    int input_stalls;
    int mismatches;

    td_value_table_update u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in       (i_in),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_out_item predict_td(input t_in_item item);
        t_out_item res;
        int idx_new;
        int idx_old;
        longint v_new;
        longint v_old;
        longint disc;
        longint diff;
        longint step;
        longint sum;
        res = '0;
        if (int'(item.slot) < SLOTS) begin
            idx_new = int'(item.slot) * ROW_LEN + (int'(item.new_chromosome) & (ROW_LEN - 1));
            idx_old = int'(item.slot) * ROW_LEN + (int'(item.old_chromosome) & (ROW_LEN - 1));
            v_new = longint'(model_values[idx_new]);
            if (item.opcode == OP_QUERY) begin
                res.value_out = model_values[idx_new];
            end else begin
                v_old = longint'(model_values[idx_old]);
                // arithmetic shift of a signed product rounds towards minus infinity
                disc = (longint'(discount_q15) * v_new) >>> 15;
                diff = longint'(item.reward) + disc - v_old;
                step = (longint'(rate_q15) * diff) >>> 15;
                sum  = v_old + step;
                if (sum > SUM_MAX) begin
                    sum = SUM_MAX;
                    res.saturated = 1'b1;
                end else if (sum < SUM_MIN) begin
                    sum = SUM_MIN;
                    res.saturated = 1'b1;
                end
                model_values[idx_old] = 32'(sum);
                res.value_out = 32'(sum);
            end
        end
        return res;
    endfunction

    function automatic t_in_item make_item(input logic op, input logic [3:0] slot,
                                           input logic [7:0] new_chrom,
                                           input logic [7:0] old_chrom,
                                           input logic signed [31:0] reward);
        t_in_item item;
        item.opcode         = op;
        item.slot           = slot;
        item.new_chromosome = new_chrom;
        item.old_chromosome = old_chrom;
        item.reward         = reward;
        return item;
    endfunction

    function automatic logic signed [31:0] rand_reward();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return VAL_MAX;
            2: return VAL_MIN;
            default: return 32'($urandom_range(0, 262143)) - 32'd131072;
        endcase
    endfunction

    // entered and left at a falling edge; push stays high between back-to-back requests
    task automatic send_request(input t_in_item item);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_in <= item;
        @(posedge i_clk);
        while (full) begin
            input_stalls++;
            @(posedge i_clk);
        end
        pending_results.push_back(predict_td(item));
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LEARN_RATE: rate_q15 = data;
            CFG_DISCOUNT:   discount_q15 = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_rates(input logic [15:0] rate, input logic [15:0] disc);
        wait_drained();
        write_reg(CFG_LEARN_RATE, rate);
        write_reg(CFG_DISCOUNT, disc);
    endtask

    // td episodes over a small working set so that entries get revisited
    task automatic run_episodes(input int count);
        logic [3:0] slot_pool [4];
        logic [7:0] chrom_pool [8];
        logic [7:0] prev_chrom;
        t_in_item   item;
        int         pick;
        foreach (slot_pool[i]) slot_pool[i] = 4'($urandom_range(0, 15));
        foreach (chrom_pool[i]) chrom_pool[i] = 8'($urandom_range(0, 255));
        prev_chrom = chrom_pool[0];
        for (int n = 0; n < count; n++) begin
            pick        = $urandom_range(0, 99);
            item.slot   = slot_pool[$urandom_range(0, 3)];
            item.reward = rand_reward();
            if (pick < 70) begin
                item.opcode         = OP_UPDATE;
                item.old_chromosome = prev_chrom;
                item.new_chromosome = chrom_pool[$urandom_range(0, 7)];
                prev_chrom          = item.new_chromosome;
            end else if (pick < 85) begin
                item.opcode         = OP_QUERY;
                item.new_chromosome = chrom_pool[$urandom_range(0, 7)];
                item.old_chromosome = 8'($urandom_range(0, 255));
            end else begin
                item.opcode         = 1'($urandom_range(0, 1));
                item.slot           = 4'($urandom_range(0, 15));
                item.new_chromosome = 8'($urandom_range(0, 255));
                item.old_chromosome = 8'($urandom_range(0, 255));
                item.reward         = $urandom();
            end
            send_request(item);
        end
    endtask

    task automatic test_reset_defaults();
        send_request(make_item(OP_QUERY,  4'd0,  8'd0,   8'd0,   32'sd0));
        send_request(make_item(OP_UPDATE, 4'd0,  8'd0,   8'd0,   VAL_MAX));
        // same old and new chromosome
        send_request(make_item(OP_UPDATE, 4'd0,  8'd0,   8'd0,   VAL_MAX));
        send_request(make_item(OP_QUERY,  4'd0,  8'd0,   8'd255, 32'sd0));
        send_request(make_item(OP_UPDATE, 4'd15, 8'd255, 8'd255, VAL_MIN));
        send_request(make_item(OP_QUERY,  4'd15, 8'd255, 8'd0,   VAL_MIN));
        send_request(make_item(OP_UPDATE, 4'd15, 8'd255, 8'd0,   VAL_MAX));
        send_request(make_item(OP_UPDATE, 4'd15, 8'd0,   8'd255, -32'sd1));
        send_request(make_item(OP_QUERY,  4'd15, 8'd0,   8'd0,   32'sd0));
        send_request(make_item(OP_QUERY,  4'd7,  8'hAA,  8'h55,  32'sd0));
    endtask

    task automatic test_rate_extremes();
        set_rates(Q15_ONE, Q15_ONE);
        send_request(make_item(OP_UPDATE, 4'd3, 8'd2, 8'd2, VAL_MAX));
        // clamps high
        send_request(make_item(OP_UPDATE, 4'd3, 8'd2, 8'd2, VAL_MAX));
        send_request(make_item(OP_UPDATE, 4'd3, 8'd3, 8'd3, VAL_MIN));
        // clamps low
        send_request(make_item(OP_UPDATE, 4'd3, 8'd3, 8'd3, VAL_MIN));
        send_request(make_item(OP_QUERY,  4'd3, 8'd2, 8'd3, 32'sd0));
        // rates above one
        set_rates(Q15_MAX, Q15_MAX);
        send_request(make_item(OP_UPDATE, 4'd4, 8'd2, 8'd1, 32'sd1000));
        send_request(make_item(OP_UPDATE, 4'd4, 8'd1, 8'd2, -32'sd1000));
        send_request(make_item(OP_UPDATE, 4'd3, 8'd2, 8'd5, 32'sd0));
        send_request(make_item(OP_UPDATE, 4'd3, 8'd3, 8'd6, 32'sd0));
        set_rates(16'd0, 16'd0);
        send_request(make_item(OP_UPDATE, 4'd3, 8'd2, 8'd2, VAL_MIN));
        send_request(make_item(OP_UPDATE, 4'd0, 8'd0, 8'd0, VAL_MAX));
    endtask

    // writes beyond the register list must leave the rates alone
    task automatic test_unused_register_index();
        wait_drained();
        write_reg(CFG_SPARE_2, Q15_MAX);
        write_reg(CFG_SPARE_3, Q15_MAX);
        send_request(make_item(OP_UPDATE, 4'd3, 8'd2, 8'd2, VAL_MAX));
        send_request(make_item(OP_QUERY,  4'd3, 8'd2, 8'd2, 32'sd0));
    endtask

    task automatic test_random_episodes();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        set_rates(LEARN_RATE_RST, DISCOUNT_RST);
        run_episodes(110);
        set_rates(Q15_ONE, Q15_ONE);
        run_episodes(110);
        set_rates(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_episodes(110);
        set_rates(16'd16384, Q15_MAX);
        run_episodes(110);
        set_rates(16'd1, 16'd1);
        run_episodes(110);
    endtask

    task automatic test_backpressure();
        set_rates(LEARN_RATE_RST, DISCOUNT_RST);
        tx_idle_on = 1'b0;
        long_hold_cycles = LONG_HOLD;
        run_episodes(120);
    endtask

    task automatic test_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_rates(16'($urandom_range(1, 32768)), 16'($urandom_range(0, 32768)));
        run_episodes(150);
    endtask

    // receiver side: pop with random idle bursts and one long hold-off on request
    initial begin : result_drain
        int burst_left;
        int hold_left;
        burst_left = 0;
        hold_left  = 0;
        pop <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_cycles > 0) begin
                hold_left        = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                pop <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(1, 15) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (pop && !empty) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: value %h sat %b", o_res.value_out,
                             o_res.saturated);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_res.saturated)
                    saturations_seen++;
                if (o_res.value_out !== want.value_out || o_res.saturated !== want.saturated)
                begin
                    if (mismatches < 10)
                        $display("result %0d mismatch: value exp %h got %h, sat exp %b got %b",
                                 results_checked, want.value_out, o_res.value_out,
                                 want.saturated, o_res.saturated);
                    mismatches++;
                end
            end
        end
    end

    initial begin : run_tests
        push       <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_LEARN_RATE;
        i_cfg_data <= '0;
        i_rst_n    <= 1'b0;
        foreach (model_values[i]) model_values[i] = '0;
        rate_q15         = LEARN_RATE_RST;
        discount_q15     = DISCOUNT_RST;
        tx_idle_on       = 1'b0;
        rx_idle_on       = 1'b0;
        long_hold_cycles = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_rate_extremes();
        test_unused_register_index();
        test_random_episodes();
        test_backpressure();
        test_no_idle();
        wait_drained();

        $display("%0d requests, %0d results checked, %0d clamped, %0d cycles with input held off",
                 requests_sent, results_checked, saturations_seen, input_stalls);
        $display("rates covered zero, one, full scale and random, with and without idling");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
